@@ design/shadow_csr_bank_emulator_assert.svh @@
// Assertion macros used by the checker of the shadow CSR bank.
`ifndef SHADOW_CSR_BANK_EMULATOR_ASSERT_SVH
`define SHADOW_CSR_BANK_EMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shadow CSR bank assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCBE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shadow CSR bank assertion failed");

`endif

@@ design/scbe_pkg.sv @@
package scbe_pkg;

    localparam int PMP_CFG_WORDS  = 4;
    localparam int PMP_ADDR_WORDS = 16;

    localparam int BANK_FIXED = 8;
    localparam int BANK_DEPTH = BANK_FIXED + PMP_CFG_WORDS + PMP_ADDR_WORDS;
    localparam int BANK_IW    = $clog2(BANK_DEPTH);

    typedef logic [BANK_IW-1:0] t_bank_idx;

    localparam t_bank_idx IDX_STATUS  = BANK_IW'(0);
    localparam t_bank_idx IDX_MIE     = BANK_IW'(1);
    localparam t_bank_idx IDX_MTVEC   = BANK_IW'(2);
    localparam t_bank_idx IDX_SCRATCH = BANK_IW'(3);
    localparam t_bank_idx IDX_MEPC    = BANK_IW'(4);
    localparam t_bank_idx IDX_MCAUSE  = BANK_IW'(5);
    localparam t_bank_idx IDX_MTVAL   = BANK_IW'(6);
    localparam t_bank_idx IDX_MIP     = BANK_IW'(7);
    localparam t_bank_idx IDX_PMPCFG0 = BANK_IW'(BANK_FIXED);
    localparam t_bank_idx IDX_PMPADR0 = BANK_IW'(BANK_FIXED + PMP_CFG_WORDS);

    localparam logic [11:0] CSR_FFLAGS    = 12'h001;
    localparam logic [11:0] CSR_FRM       = 12'h002;
    localparam logic [11:0] CSR_FCSR      = 12'h003;
    localparam logic [11:0] CSR_STATUS    = 12'h300;
    localparam logic [11:0] CSR_MISA      = 12'h301;
    localparam logic [11:0] CSR_MIE       = 12'h304;
    localparam logic [11:0] CSR_VEC_BASE  = 12'h305;
    localparam logic [11:0] CSR_SCRATCH   = 12'h340;
    localparam logic [11:0] CSR_EXC_PC    = 12'h341;
    localparam logic [11:0] CSR_CAUSE     = 12'h342;
    localparam logic [11:0] CSR_TRAP_VAL  = 12'h343;
    localparam logic [11:0] CSR_MIP       = 12'h344;
    localparam logic [11:0] CSR_PROT_CFG0 = 12'h3a0;
    localparam logic [11:0] CSR_PROT_ADDR0 = 12'h3b0;
    localparam logic [11:0] CSR_MVENDORID = 12'hf11;
    localparam logic [11:0] CSR_MARCHID   = 12'hf12;
    localparam logic [11:0] CSR_MIMPID    = 12'hf13;
    localparam logic [11:0] CSR_MHARTID   = 12'hf14;

    localparam logic [6:0]  OPC_SYSTEM = 7'h73;
    localparam logic [31:0] INSN_MRET  = 32'h3020_0073;
    localparam logic [31:0] INSN_WFI   = 32'h1050_0073;

    localparam logic [2:0] F3_PRIV     = 3'd0;
    localparam logic [2:0] F3_CSRRW    = 3'd1;
    localparam logic [2:0] F3_CSRRS    = 3'd2;
    localparam logic [2:0] F3_CSRRC    = 3'd3;
    localparam logic [2:0] F3_RESERVED = 3'd4;
    localparam logic [2:0] F3_CSRRWI   = 3'd5;
    localparam logic [2:0] F3_CSRRSI   = 3'd6;
    localparam logic [2:0] F3_CSRRCI   = 3'd7;

    localparam logic [1:0] OP_SWAP = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    localparam logic [31:0] MIP_HW_BITS    = 32'h0000_0880;
    localparam logic [31:0] MSTATUS_RESET  = 32'h0000_1800;

    localparam logic [1:0] OUT_ADVANCE   = 2'd0;
    localparam logic [1:0] OUT_RESUME    = 2'd1;
    localparam logic [1:0] OUT_UNHANDLED = 2'd2;

    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    typedef struct packed {
        logic      hit;
        logic      mip;
        t_bank_idx idx;
    } t_map;

    typedef struct packed {
        logic        en;
        t_bank_idx   idx;
        logic [31:0] data;
    } t_bank_wr;

    function automatic t_map csr_map(input logic [11:0] num);
        t_map m;
        m.hit = 1'b1;
        m.mip = 1'b0;
        m.idx = IDX_STATUS;
        case (num)
            CSR_STATUS:   m.idx = IDX_STATUS;
            CSR_MIE:      m.idx = IDX_MIE;
            CSR_VEC_BASE: m.idx = IDX_MTVEC;
            CSR_SCRATCH:  m.idx = IDX_SCRATCH;
            CSR_EXC_PC:   m.idx = IDX_MEPC;
            CSR_CAUSE:    m.idx = IDX_MCAUSE;
            CSR_TRAP_VAL: m.idx = IDX_MTVAL;
            CSR_MIP: begin
                m.idx = IDX_MIP;
                m.mip = 1'b1;
            end
            default: begin
                if (num >= CSR_PROT_CFG0 && num < CSR_PROT_CFG0 + 12'(PMP_CFG_WORDS)) begin
                    m.idx = BANK_IW'(num - CSR_PROT_CFG0) + IDX_PMPCFG0;
                end else if (num >= CSR_PROT_ADDR0 &&
                             num < CSR_PROT_ADDR0 + 12'(PMP_ADDR_WORDS)) begin
                    m.idx = BANK_IW'(num - CSR_PROT_ADDR0) + IDX_PMPADR0;
                end else begin
                    m.hit = 1'b0;
                end
            end
        endcase
        return m;
    endfunction

    function automatic logic csr_reads_zero(input logic [11:0] num);
        logic z;
        case (num)
            CSR_FFLAGS, CSR_FRM, CSR_FCSR, CSR_MISA,
            CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID: z = 1'b1;
            default: z = 1'b0;
        endcase
        return z;
    endfunction

    function automatic logic [31:0] bank_reset(input t_bank_idx idx);
        return (idx == IDX_STATUS) ? MSTATUS_RESET : 32'd0;
    endfunction

endpackage

@@ design/scbe_bank.sv @@
module scbe_bank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  scbe_pkg::t_bank_idx  i_rd_idx,
    input  scbe_pkg::t_bank_wr   i_wr,
    output logic [31:0]          o_rd_data,
    output logic [31:0]          o_pc_data
);
    import scbe_pkg::*;

    logic [31:0]           r_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] r_vld;
    logic [31:0]           r_data_a;
    logic [31:0]           r_data_b;
    logic                  r_vld_a;
    logic                  r_vld_b;
    t_bank_idx             r_idx_a;

    // Entries never written since reset read as their reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_data_a <= r_mem[i_rd_idx];
            r_vld_a  <= r_vld[i_rd_idx];
            r_idx_a  <= i_rd_idx;
            r_data_b <= r_mem[IDX_MEPC];
            r_vld_b  <= r_vld[IDX_MEPC];
        end
    end

    assign o_rd_data = r_vld_a ? r_data_a : bank_reset(r_idx_a);
    assign o_pc_data = r_vld_b ? r_data_b : bank_reset(IDX_MEPC);

endmodule

@@ design/shadow_csr_bank_emulator.sv @@
// Shadow machine CSR bank for trapped RV32 SYSTEM instructions. For each
// word, the edge that accepts it reads the shadow RAM, and the next edge
// modifies the entry, writes it back and loads the output register. A new
// word is accepted only when no earlier word is still in the single
// read-modify-write of the shadow RAM, and only while the output register
// is empty or is being read in the same cycle. The RAM needs no clearing
// pass after reset; entries read as their reset values until first written.
module shadow_csr_bank_emulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_rs1_value,
    input  logic        i_timer_pending,
    input  logic        i_external_pending,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_outcome,
    output logic [4:0]  o_dest_index,
    output logic        o_dest_write,
    output logic [31:0] o_dest_value,
    output logic [31:0] o_resume_pc,
    output logic [1:0]  o_privilege_now
);
    import scbe_pkg::*;

    typedef enum logic [2:0] {
        K_UNHANDLED,
        K_WFI,
        K_MRET,
        K_CSR,
        K_ZERO
    } t_kind;

    logic        r_busy;
    logic        r_out_valid;
    logic [1:0]  r_priv;
    t_kind       r_kind;
    logic [1:0]  r_op;
    logic [31:0] r_src;
    logic        r_wr;
    logic        r_mip;
    logic        r_tp;
    logic        r_ep;
    logic [4:0]  r_rd;
    t_bank_idx   r_idx;

    logic [1:0]  r_outcome;
    logic [4:0]  r_dest_index;
    logic        r_dest_write;
    logic [31:0] r_dest_value;
    logic [31:0] r_resume_pc;

    logic        accept;
    logic [2:0]  f3;
    logic [4:0]  rs;
    t_map        map;
    t_kind       dec_kind;
    t_bank_idx   dec_idx;
    logic [31:0] dec_src;

    logic [31:0] bank_old;
    logic [31:0] pc_old;
    logic [31:0] old;
    logic [31:0] upd;
    logic [31:0] st_new;
    logic        csr_done;
    logic [1:0]  n_priv;
    logic [1:0]  n_outcome;
    t_bank_wr    wr;

    assign o_in_ready = i_rst_n && !r_busy && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign f3  = i_instruction[14:12];
    assign rs  = i_instruction[19:15];
    assign map = csr_map(i_instruction[31:20]);

    always_comb begin
        dec_kind = K_UNHANDLED;
        if (i_instruction[6:0] == OPC_SYSTEM) begin
            if (f3 == F3_PRIV) begin
                if (i_instruction == INSN_MRET) begin
                    dec_kind = K_MRET;
                end else if (i_instruction == INSN_WFI) begin
                    dec_kind = K_WFI;
                end
            end else if (f3 != F3_RESERVED) begin
                if (map.hit) begin
                    dec_kind = K_CSR;
                end else if (csr_reads_zero(i_instruction[31:20])) begin
                    dec_kind = K_ZERO;
                end
            end
        end
    end

    assign dec_idx = (dec_kind == K_MRET) ? IDX_STATUS : map.idx;
    assign dec_src = f3[2] ? {27'd0, rs} : ((rs == 5'd0) ? 32'd0 : i_rs1_value);

    scbe_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_idx  (dec_idx),
        .i_wr      (wr),
        .o_rd_data (bank_old),
        .o_pc_data (pc_old)
    );

    always_comb begin
        if (r_kind == K_ZERO) begin
            old = 32'd0;
        end else if (r_mip) begin
            old = (bank_old & ~MIP_HW_BITS) | {20'd0, r_ep, 3'd0, r_tp, 7'd0};
        end else begin
            old = bank_old;
        end

        case (r_op)
            OP_SWAP: upd = r_src;
            OP_SET:  upd = old | r_src;
            default: upd = old & ~r_src;
        endcase

        st_new     = bank_old;
        st_new[3]  = bank_old[7];
        st_new[7]  = 1'b1;
        st_new[12:11] = 2'd0;

        csr_done = (r_kind == K_CSR) || (r_kind == K_ZERO);
        n_priv   = (r_kind == K_MRET) ? bank_old[12:11] : r_priv;

        case (r_kind)
            K_WFI, K_CSR, K_ZERO: n_outcome = OUT_ADVANCE;
            K_MRET:  n_outcome = (pc_old == 32'd0) ? OUT_UNHANDLED : OUT_RESUME;
            default: n_outcome = OUT_UNHANDLED;
        endcase

        wr.en   = r_busy && (((r_kind == K_CSR) && r_wr) || (r_kind == K_MRET));
        wr.idx  = r_idx;
        if (r_kind == K_MRET) begin
            wr.data = st_new;
        end else if (r_mip) begin
            wr.data = upd & ~MIP_HW_BITS;
        end else begin
            wr.data = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_priv      <= PRIV_MACHINE;
        end else begin
            r_busy <= accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_priv      <= n_priv;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= dec_kind;
            r_op   <= f3[1:0];
            r_src  <= dec_src;
            r_wr   <= (f3[1:0] == OP_SWAP) || (rs != 5'd0);
            r_mip  <= map.mip && (dec_kind == K_CSR);
            r_tp   <= i_timer_pending;
            r_ep   <= i_external_pending;
            r_rd   <= i_instruction[11:7];
            r_idx  <= dec_idx;
        end
        if (r_busy) begin
            r_outcome    <= n_outcome;
            r_dest_write <= csr_done && (r_rd != 5'd0);
            r_dest_value <= csr_done ? old : 32'd0;
            r_resume_pc  <= (n_outcome == OUT_RESUME) ? pc_old : 32'd0;
            r_dest_index <= r_rd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_outcome       = r_outcome;
    assign o_dest_index    = r_dest_index;
    assign o_dest_write    = r_dest_write;
    assign o_dest_value    = r_dest_value;
    assign o_resume_pc     = r_resume_pc;
    assign o_privilege_now = r_priv;

endmodule

@@ design/scbe_checker.sv @@
`include "shadow_csr_bank_emulator_assert.svh"

module scbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_outcome,
    input logic        o_dest_write,
    input logic [31:0] o_dest_value,
    input logic [31:0] o_resume_pc
);
    import scbe_pkg::*;

    logic resume_out;
    logic write_out;
    logic in_fire;
    logic out_stall;

    assign resume_out = o_out_valid && (o_outcome == OUT_RESUME);
    assign write_out  = o_out_valid && o_dest_write;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_stall  = o_out_valid && !i_out_ready;

    // A resumed word never jumps to address zero.
    `SCBE_ASSERT_IMP(a_resume_nonzero, i_clk, i_rst_n, resume_out, o_resume_pc != 32'd0)

    // Only an advancing word may write a destination register.
    `SCBE_ASSERT_IMP(a_write_on_advance, i_clk, i_rst_n, write_out, o_outcome == OUT_ADVANCE)

    // A word is processed one at a time, so ready drops after each acceptance.
    `SCBE_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, in_fire, !o_in_ready)

    // A stalled result holds its value.
    `SCBE_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_dest_value))

endmodule

bind shadow_csr_bank_emulator scbe_checker u_scbe_checker (.*);
